// ===== src/eff_pkg.sv =====
// Shared constants, types and the logistic table of the fringe-field evaluator.
package eff_pkg;

  // Number formats
  localparam int POS_WIDTH  = 16;
  localparam int FRAC_BITS  = 12;
  localparam int COEF_FRAC  = 8;
  localparam int HL_W       = 15;
  localparam int ITR_W      = 15;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths
  localparam int OFF_W      = POS_WIDTH + 1;
  localparam int UPROD_W    = OFF_W + ITR_W + 1;
  localparam int U_W        = UPROD_W - FRAC_BITS;
  localparam int ACC_W      = 49;                 // holds +-2^47
  localparam int MUL_LO_W   = 25;
  localparam int MUL_HI_W   = ACC_W - MUL_LO_W;
  localparam int PROD_W     = ACC_W + U_W;
  localparam int RND_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W      = RND_W + 1;

  // Logistic table
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_ONE_B  = 30;                 // Q1.30
  localparam int SIG_W      = SIG_ONE_B + 1;
  localparam int LOG_FB     = FRAC_BITS + 4;
  localparam int LOG_DB     = $clog2(SIG_DEPTH);
  localparam int LOG_SHIFT  = LOG_FB - LOG_DB;
  localparam int UA_W       = FRAC_BITS + 5;      // |a| up to 16.0
  localparam int IDX_W      = UA_W - LOG_SHIFT;
  localparam longint SIG_STEP = (longint'(16) << SIG_ONE_B) / SIG_DEPTH;

  // Pipeline stage indexes
  localparam int ST_OFF      = 0;
  localparam int ST_UPROD    = 1;
  localparam int ST_U        = 2;
  localparam int ST_HORNER   = 3;                 // two stages per Horner step
  localparam int NUM_STEPS   = 5;
  localparam int ST_LOG_PREP = ST_HORNER + 2 * NUM_STEPS;
  localparam int ST_LOG_TAB  = ST_LOG_PREP + 1;
  localparam int ST_LOG_OUT  = ST_LOG_TAB + 1;
  localparam int ST_SPROD    = ST_LOG_OUT + 1;
  localparam int ST_SRND     = ST_SPROD + 1;
  localparam int ST_FPROD    = ST_SRND + 1;
  localparam int ST_OUT      = ST_FPROD + 1;
  localparam int NUM_STAGES  = ST_OUT + 1;

  typedef logic [NUM_STAGES-1:0] stage_en_t;
  typedef logic [SIG_DEPTH:0][SIG_W-1:0] sig_tab_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENT_LO  = 3'd0,
    CFG_ENT_HI  = 3'd1,
    CFG_EXT_LO  = 3'd2,
    CFG_EXT_HI  = 3'd3,
    CFG_HALF_L  = 3'd4,
    CFG_INV_2R  = 3'd5,
    CFG_PEAK    = 3'd6
  } cfg_idx_e;

  // Q8.8 coefficient k of a packed pair of registers, scaled to Q.FRAC_BITS
  function automatic logic signed [ACC_W-1:0] coef_f(input logic [63:0] lo,
                                                     input logic [31:0] hi,
                                                     input int unsigned k);
    logic [15:0] c;
    if (k < 4) begin
      c = lo[16*k +: 16];
    end else begin
      c = hi[16*(k-4) +: 16];
    end
    return ACC_W'($signed(c)) <<< (FRAC_BITS - COEF_FRAC);
  endfunction

  // nonnegative quotient by shift and subtract, used while building the table
  function automatic longint udiv_f(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  // g(x) = 1/(1+exp(-x)) in Q1.30 over [0,16], exp step from a Taylor series
  function automatic sig_tab_t build_sig_tab_f();
    longint h;
    longint r;
    longint term;
    longint p;
    longint den;
    sig_tab_t tab;
    h    = SIG_STEP;
    r    = longint'(1) << SIG_ONE_B;
    term = longint'(1) << SIG_ONE_B;
    p    = longint'(1) << SIG_ONE_B;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * h) + (longint'(1) << (SIG_ONE_B - 1))) >>> SIG_ONE_B;
      term = udiv_f(term, longint'(n));
      if ((n & 1) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      den    = (longint'(1) << SIG_ONE_B) + p;
      tab[k] = SIG_W'(udiv_f((longint'(1) << (2 * SIG_ONE_B)) + (den >>> 1), den));
      p      = ((p * r) + (longint'(1) << (SIG_ONE_B - 1))) >>> SIG_ONE_B;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab_f();

endpackage

// ===== src/eff_stream_if.sv =====
// Valid/ready stream interfaces for positions and field values.
interface eff_pos_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [eff_pkg::POS_WIDTH-1:0]    position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface eff_field_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [eff_pkg::POS_WIDTH-1:0]    field_value;
  modport source (output valid, output field_value, input ready);
  modport sink   (input valid, input field_value, output ready);
endinterface

// ===== src/eff_horner_step.sv =====
// One Horner step: acc*u split in two partial products, then round, add coefficient, clamp.
module eff_horner_step #(
  parameter int STAGE = eff_pkg::ST_HORNER
) (
  input  logic                               clk_i,
  input  eff_pkg::stage_en_t                 en_i,
  input  logic signed [eff_pkg::ACC_W-1:0]   acc_i,
  input  logic signed [eff_pkg::U_W-1:0]     u_i,
  input  logic signed [eff_pkg::ACC_W-1:0]   coef_i,
  output logic signed [eff_pkg::ACC_W-1:0]   acc_o,
  output logic signed [eff_pkg::U_W-1:0]     u_o
);
  localparam int PLO_W = eff_pkg::MUL_LO_W + 1 + eff_pkg::U_W;
  localparam int PHI_W = eff_pkg::MUL_HI_W + eff_pkg::U_W;
  localparam logic signed [eff_pkg::SUM_W-1:0] SUM_LIM =
    eff_pkg::SUM_W'(1) << (eff_pkg::ACC_W - 2);

  logic signed [PLO_W-1:0]            plo_d, plo_q;
  logic signed [PHI_W-1:0]            phi_d, phi_q;
  logic signed [eff_pkg::U_W-1:0]     ua_q, ub_q;
  logic signed [eff_pkg::PROD_W-1:0]  prod;
  logic signed [eff_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [eff_pkg::SUM_W-1:0]   sum;
  logic signed [eff_pkg::ACC_W-1:0]   acc_d, acc_q;

  // partial products: unsigned low slice and signed high slice
  assign plo_d = $signed({1'b0, acc_i[eff_pkg::MUL_LO_W-1:0]}) * u_i;
  assign phi_d = $signed(acc_i[eff_pkg::ACC_W-1:eff_pkg::MUL_LO_W]) * u_i;

  // recombine, round half up, add coefficient, clamp to +-2^47
  always_comb begin
    prod     = (eff_pkg::PROD_W'(phi_q) <<< eff_pkg::MUL_LO_W) + eff_pkg::PROD_W'(plo_q);
    prod_rnd = prod + (eff_pkg::PROD_W'(1) <<< (eff_pkg::FRAC_BITS - 1));
    sum      = eff_pkg::SUM_W'($signed(prod_rnd[eff_pkg::PROD_W-1:eff_pkg::FRAC_BITS]))
             + eff_pkg::SUM_W'(coef_i);
    if (sum > SUM_LIM) begin
      acc_d = eff_pkg::ACC_W'(SUM_LIM);
    end else if (sum < -SUM_LIM) begin
      acc_d = eff_pkg::ACC_W'(-SUM_LIM);
    end else begin
      acc_d = eff_pkg::ACC_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[STAGE]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      ua_q  <= u_i;
    end
    if (en_i[STAGE+1]) begin
      acc_q <= acc_d;
      ub_q  <= ua_q;
    end
  end

  assign acc_o = acc_q;
  assign u_o   = ub_q;
endmodule

// ===== src/eff_logistic.sv =====
// Logistic 1/(1+exp(-a)) by table lookup and linear interpolation, three stages.
module eff_logistic (
  input  logic                               clk_i,
  input  eff_pkg::stage_en_t                 en_i,
  input  logic signed [eff_pkg::ACC_W-1:0]   a_i,
  output logic [eff_pkg::SIG_W-1:0]          s_o
);
  localparam logic signed [eff_pkg::ACC_W-1:0] A_LIM =
    eff_pkg::ACC_W'(16) <<< eff_pkg::FRAC_BITS;
  localparam int DP_W = eff_pkg::SIG_W + 1 + eff_pkg::LOG_SHIFT + 1;

  logic signed [eff_pkg::ACC_W-1:0]   a_c, a_abs;
  logic [eff_pkg::IDX_W-1:0]          idx_q, idx_n;
  logic [eff_pkg::LOG_SHIFT-1:0]      fr_q;
  logic                               neg_q, neg2_q;
  logic signed [eff_pkg::SIG_W:0]     diff;
  logic [eff_pkg::SIG_W-1:0]          base_d, base_q;
  logic signed [DP_W-1:0]             dp_d, dp_q, dp_rnd;
  logic signed [eff_pkg::SIG_W+1:0]   g;
  logic [eff_pkg::SIG_W-1:0]          s_d, s_q;

  // saturate to +-16 and take the magnitude
  always_comb begin
    if (a_i > A_LIM) begin
      a_c = A_LIM;
    end else if (a_i < -A_LIM) begin
      a_c = -A_LIM;
    end else begin
      a_c = a_i;
    end
    a_abs = a_c[eff_pkg::ACC_W-1] ? -a_c : a_c;
  end

  // table read at idx and idx+1, slope times fraction
  always_comb begin
    idx_n = idx_q + eff_pkg::IDX_W'(1);
    if (idx_q == eff_pkg::IDX_W'(eff_pkg::SIG_DEPTH)) begin
      base_d = eff_pkg::SIG_TAB[eff_pkg::SIG_DEPTH];
      diff   = '0;
    end else begin
      base_d = eff_pkg::SIG_TAB[idx_q];
      diff   = $signed({1'b0, eff_pkg::SIG_TAB[idx_n]}) - $signed({1'b0, base_d});
    end
    dp_d = diff * $signed({1'b0, fr_q});
  end

  // interpolate and mirror for negative arguments
  always_comb begin
    dp_rnd = dp_q + (DP_W'(1) <<< (eff_pkg::LOG_SHIFT - 1));
    g      = $signed({2'b00, base_q})
           + (eff_pkg::SIG_W+2)'(dp_rnd[DP_W-1:eff_pkg::LOG_SHIFT]);
    if (neg2_q) begin
      s_d = eff_pkg::SIG_W'((eff_pkg::SIG_W+2)'(1) <<< eff_pkg::SIG_ONE_B) - eff_pkg::SIG_W'(g);
    end else begin
      s_d = eff_pkg::SIG_W'(g);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[eff_pkg::ST_LOG_PREP]) begin
      idx_q <= a_abs[eff_pkg::UA_W-1:eff_pkg::LOG_SHIFT];
      fr_q  <= a_abs[eff_pkg::LOG_SHIFT-1:0];
      neg_q <= a_c[eff_pkg::ACC_W-1];
    end
    if (en_i[eff_pkg::ST_LOG_TAB]) begin
      base_q <= base_d;
      dp_q   <= dp_d;
      neg2_q <= neg_q;
    end
    if (en_i[eff_pkg::ST_LOG_OUT]) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;
endmodule

// ===== src/eff_side.sv =====
// One magnet end: offset scaling, fifth-order Horner chain and logistic.
module eff_side (
  input  logic                               clk_i,
  input  eff_pkg::stage_en_t                 en_i,
  input  logic signed [eff_pkg::OFF_W-1:0]   off_i,
  input  logic [eff_pkg::ITR_W-1:0]          inv_two_radius_i,
  input  logic [63:0]                        coefs_low_i,
  input  logic [31:0]                        coefs_high_i,
  output logic [eff_pkg::SIG_W-1:0]          s_o
);
  logic signed [eff_pkg::UPROD_W-1:0] uprod_d, uprod_q, uprod_rnd;
  logic signed [eff_pkg::U_W-1:0]     u_c   [0:eff_pkg::NUM_STEPS];
  logic signed [eff_pkg::ACC_W-1:0]   acc_c [0:eff_pkg::NUM_STEPS];
  logic signed [eff_pkg::U_W-1:0]     u_q;
  logic signed [eff_pkg::ACC_W-1:0]   acc0_q;

  // scaled offset u = round(off * inv_two_radius)
  assign uprod_d   = $signed(off_i) * $signed({1'b0, inv_two_radius_i});
  assign uprod_rnd = uprod_q + (eff_pkg::UPROD_W'(1) <<< (eff_pkg::FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (en_i[eff_pkg::ST_UPROD]) begin
      uprod_q <= uprod_d;
    end
    if (en_i[eff_pkg::ST_U]) begin
      u_q    <= uprod_rnd[eff_pkg::UPROD_W-1:eff_pkg::FRAC_BITS];
      acc0_q <= eff_pkg::coef_f(coefs_low_i, coefs_high_i, 5);
    end
  end

  assign u_c[0]   = u_q;
  assign acc_c[0] = acc0_q;

  // Horner steps for terms four down to zero
  for (genvar j = 0; j < eff_pkg::NUM_STEPS; j++) begin : g_step
    eff_horner_step #(
      .STAGE (eff_pkg::ST_HORNER + 2 * j)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .acc_i  (acc_c[j]),
      .u_i    (u_c[j]),
      .coef_i (eff_pkg::coef_f(coefs_low_i, coefs_high_i, 4 - j)),
      .acc_o  (acc_c[j+1]),
      .u_o    (u_c[j+1])
    );
  end

  eff_logistic u_logistic (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (acc_c[eff_pkg::NUM_STEPS]),
    .s_o   (s_o)
  );
endmodule

// ===== src/enge_fringe_field_eval.sv =====
// Throughput: one position per cycle unless a stalled output has filled every stage;
// the 20-stage pipeline holds up to 20 items in flight.
// A stalled output only backs up stages that are full; empty stages keep accepting.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the register defaults.
// The logistic table is a constant; no clearing pass is needed after reset.
module enge_fringe_field_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  eff_pos_if.sink                           pos_in,
  eff_field_if.source                       field_out,
  input  logic                              cfg_we_i,
  input  logic [eff_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eff_pkg::CFG_W-1:0]         cfg_data_i
);
  localparam int SP_W = 2 * eff_pkg::SIG_W;
  localparam int FP_W = eff_pkg::POS_WIDTH + eff_pkg::SIG_W + 1;
  localparam int RS_W = FP_W - eff_pkg::SIG_ONE_B;
  localparam logic signed [RS_W-1:0] OUT_MAX = RS_W'((1 << (eff_pkg::POS_WIDTH - 1)) - 1);
  localparam logic signed [RS_W-1:0] OUT_MIN = -OUT_MAX - RS_W'(1);

  // configuration registers
  logic [63:0]                       ent_lo_q, ext_lo_q;
  logic [31:0]                       ent_hi_q, ext_hi_q;
  logic [eff_pkg::HL_W-1:0]          half_length_q;
  logic [eff_pkg::ITR_W-1:0]         inv_two_radius_q;
  logic signed [15:0]                peak_field_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_lo_q         <= 64'd50331648;
      ent_hi_q         <= 32'd0;
      ext_lo_q         <= 64'd67108864;
      ext_hi_q         <= 32'd0;
      half_length_q    <= 15'd1434;
      inv_two_radius_q <= 15'd10240;
      peak_field_q     <= 16'sd8192;
    end else if (cfg_we_i) begin
      case (eff_pkg::cfg_idx_e'(cfg_idx_i))
        eff_pkg::CFG_ENT_LO: ent_lo_q         <= cfg_data_i;
        eff_pkg::CFG_ENT_HI: ent_hi_q         <= cfg_data_i[31:0];
        eff_pkg::CFG_EXT_LO: ext_lo_q         <= cfg_data_i;
        eff_pkg::CFG_EXT_HI: ext_hi_q         <= cfg_data_i[31:0];
        eff_pkg::CFG_HALF_L: half_length_q    <= cfg_data_i[eff_pkg::HL_W-1:0];
        eff_pkg::CFG_INV_2R: inv_two_radius_q <= cfg_data_i[eff_pkg::ITR_W-1:0];
        eff_pkg::CFG_PEAK:   peak_field_q     <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // valid chain and per-stage load enables; bubbles collapse under stall
  eff_pkg::stage_en_t v_q;
  eff_pkg::stage_en_t en;

  always_comb begin
    en[eff_pkg::NUM_STAGES-1] = !v_q[eff_pkg::NUM_STAGES-1] || field_out.ready;
    for (int i = eff_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < eff_pkg::NUM_STAGES; i++) begin
        if (en[i]) begin
          v_q[i] <= (i == 0) ? pos_in.valid : v_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign pos_in.ready = en[eff_pkg::ST_OFF];

  // entrance and exit offsets
  logic signed [eff_pkg::OFF_W-1:0] z_ext, hl_ext;
  logic signed [eff_pkg::OFF_W-1:0] off_ent_d, off_ext_d, off_ent_q, off_ext_q;

  assign z_ext     = eff_pkg::OFF_W'(pos_in.position);
  assign hl_ext    = $signed({2'b00, half_length_q});
  assign off_ent_d = z_ext - hl_ext;
  assign off_ext_d = -z_ext - hl_ext;

  always_ff @(posedge clk_i) begin
    if (en[eff_pkg::ST_OFF]) begin
      off_ent_q <= off_ent_d;
      off_ext_q <= off_ext_d;
    end
  end

  logic [eff_pkg::SIG_W-1:0] s_ent, s_ext;

  eff_side u_side_ent (
    .clk_i            (clk_i),
    .en_i             (en),
    .off_i            (off_ent_q),
    .inv_two_radius_i (inv_two_radius_q),
    .coefs_low_i      (ent_lo_q),
    .coefs_high_i     (ent_hi_q),
    .s_o              (s_ent)
  );

  eff_side u_side_ext (
    .clk_i            (clk_i),
    .en_i             (en),
    .off_i            (off_ext_q),
    .inv_two_radius_i (inv_two_radius_q),
    .coefs_low_i      (ext_lo_q),
    .coefs_high_i     (ext_hi_q),
    .s_o              (s_ext)
  );

  // product of logistics, scale by peak field, round and saturate
  logic [SP_W-1:0]                    sp_q, sp_rnd;
  logic [eff_pkg::SIG_W-1:0]          pr_q;
  logic signed [FP_W-1:0]             fp_d, fp_q, fp_rnd;
  logic signed [RS_W-1:0]             res;
  logic signed [eff_pkg::POS_WIDTH-1:0] out_d, out_q;

  always_comb begin
    sp_rnd = sp_q + (SP_W'(1) << (eff_pkg::SIG_ONE_B - 1));
    fp_d   = peak_field_q * $signed({1'b0, pr_q});
    fp_rnd = fp_q + (FP_W'(1) <<< (eff_pkg::SIG_ONE_B - 1));
    res    = fp_rnd[FP_W-1:eff_pkg::SIG_ONE_B];
    if (res > OUT_MAX) begin
      out_d = eff_pkg::POS_WIDTH'(OUT_MAX);
    end else if (res < OUT_MIN) begin
      out_d = eff_pkg::POS_WIDTH'(OUT_MIN);
    end else begin
      out_d = eff_pkg::POS_WIDTH'(res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[eff_pkg::ST_SPROD]) begin
      sp_q <= SP_W'(s_ent) * SP_W'(s_ext);
    end
    if (en[eff_pkg::ST_SRND]) begin
      pr_q <= sp_rnd[eff_pkg::SIG_ONE_B +: eff_pkg::SIG_W];
    end
    if (en[eff_pkg::ST_FPROD]) begin
      fp_q <= fp_d;
    end
    if (en[eff_pkg::ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign field_out.valid       = v_q[eff_pkg::ST_OUT];
  assign field_out.field_value = out_q;
endmodule

// ===== src/eff_checker.sv =====
// Port-level checks of the fringe-field evaluator, bound to the top level.
module eff_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [eff_pkg::POS_WIDTH-1:0]       out_data_i
);
  localparam int CNT_W = $clog2(eff_pkg::NUM_STAGES + 1);

  // items accepted and not yet delivered
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!in_xfer && out_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // input only blocked when the pipeline is full behind a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output stall");

  // no result without a pending item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without accepted item");

  // occupancy never exceeds the pipeline depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(eff_pkg::NUM_STAGES))
    else $error("more items in flight than stages");
endmodule

bind enge_fringe_field_eval eff_checker u_eff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pos_in.valid),
  .in_ready_i  (pos_in.ready),
  .out_valid_i (field_out.valid),
  .out_ready_i (field_out.ready),
  .out_data_i  (field_out.field_value)
);
